### design/llc_pkg.sv
// Shared types, constants and helper functions of the leg levelling controller.
// No dependencies; compile this file first.
package llc_pkg;

  localparam int LEGS_DEF = 6;

  // configuration register indexes
  localparam logic [2:0] REG_ROLL_GAIN    = 3'd0;
  localparam logic [2:0] REG_PITCH_GAIN   = 3'd1;
  localparam logic [2:0] REG_DEADBAND     = 3'd2;
  localparam logic [2:0] REG_ROLL_INVERT  = 3'd3;
  localparam logic [2:0] REG_PITCH_INVERT = 3'd4;
  localparam logic [2:0] REG_MAX_OFFSET   = 3'd5;
  localparam logic [2:0] REG_MAX_STEP     = 3'd6;
  localparam logic [2:0] REG_NEUTRAL      = 3'd7;

  localparam logic [11:0] ROLL_GAIN_RST  = 12'd307;
  localparam logic [11:0] PITCH_GAIN_RST = 12'd307;
  localparam logic [11:0] DEADBAND_RST   = 12'd179;
  localparam logic [7:0]  MAX_OFFSET_RST = 8'd35;
  localparam logic [7:0]  MAX_STEP_RST   = 8'd2;
  localparam logic [59:0] NEUTRAL_RST    = 60'd259133222766684320;

  // opcodes
  localparam logic [1:0] OP_LEVEL     = 2'd0;
  localparam logic [1:0] OP_ZERO_REF  = 2'd1;
  localparam logic [1:0] OP_CLEAR_OFF = 2'd2;

  // datapath operations selected by the microword
  localparam logic [3:0] DP_NOP       = 4'd0;
  localparam logic [3:0] DP_LATCH     = 4'd1;
  localparam logic [3:0] DP_ZERO      = 4'd2;
  localparam logic [3:0] DP_CLEAR     = 4'd3;
  localparam logic [3:0] DP_ERR       = 4'd4;
  localparam logic [3:0] DP_MUL_ROLL  = 4'd5;
  localparam logic [3:0] DP_MUL_PITCH = 4'd6;
  localparam logic [3:0] DP_MIX       = 4'd7;
  localparam logic [3:0] DP_TARGET    = 4'd8;
  localparam logic [3:0] DP_EMIT      = 4'd9;

  localparam logic signed [11:0] PULSE_MIN = 12'sd50;
  localparam logic signed [11:0] PULSE_MAX = 12'sd510;

  typedef struct packed {
    logic [11:0] roll_gain;
    logic [11:0] pitch_gain;
    logic [11:0] deadband;
    logic        roll_invert;
    logic        pitch_invert;
    logic [7:0]  max_offset;
    logic [7:0]  max_step;
    logic [59:0] neutral_pulses;
  } cfg_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic op_zero;
    logic op_clear;
    logic not_step;
    logic more_legs;
  } status_t;

  // roll weight already doubled; legs beyond six carry no weight
  function automatic logic signed [2:0] roll_w2(input logic [2:0] leg);
    case (leg)
      3'd0, 3'd1, 3'd2: roll_w2 = 3'sd2;
      3'd3, 3'd4, 3'd5: roll_w2 = -3'sd2;
      default:          roll_w2 = 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] pitch_w(input logic [2:0] leg);
    case (leg)
      3'd0, 3'd3: pitch_w = 3'sd2;
      3'd1, 3'd4: pitch_w = 3'sd1;
      3'd2, 3'd5: pitch_w = -3'sd2;
      default:    pitch_w = 3'sd0;
    endcase
  endfunction

  // multiply by a small weight through shift and negate
  function automatic logic signed [33:0] scale_w(input logic signed [33:0] v,
                                                 input logic signed [2:0] w);
    case (w)
      3'sd1:   scale_w = v;
      3'sd2:   scale_w = v <<< 1;
      -3'sd1:  scale_w = -v;
      -3'sd2:  scale_w = -(v <<< 1);
      default: scale_w = '0;
    endcase
  endfunction

  function automatic logic [9:0] neutral_of(input logic [59:0] np, input logic [2:0] leg);
    case (leg)
      3'd0:    neutral_of = np[9:0];
      3'd1:    neutral_of = np[19:10];
      3'd2:    neutral_of = np[29:20];
      3'd3:    neutral_of = np[39:30];
      3'd4:    neutral_of = np[49:40];
      3'd5:    neutral_of = np[59:50];
      default: neutral_of = 10'd0;
    endcase
  endfunction

endpackage

### design/llc_ifs.sv
// Request channel interfaces of the leg levelling controller.
// No dependencies; compile after llc_pkg.
interface llc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [16:0] roll_angle;
  logic signed [16:0] pitch_angle;

  modport source (output valid, opcode, roll_angle, pitch_angle, input ready);
  modport sink   (input valid, opcode, roll_angle, pitch_angle, output ready);
endinterface

interface llc_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        leg;
  logic [8:0]        pulse;
  logic signed [8:0] offset;
  logic              last;

  modport source (output valid, leg, pulse, offset, last, input ready);
  modport sink   (input valid, leg, pulse, offset, last, output ready);
endinterface

### design/llc_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on llc_pkg.
module llc_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  llc_pkg::status_t  st,
  output logic [3:0]        dp_op
);
  import llc_pkg::*;

  localparam logic [2:0] C_NEXT      = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_OP_ZERO   = 3'd2;
  localparam logic [2:0] C_OP_CLEAR  = 3'd3;
  localparam logic [2:0] C_NOT_STEP  = 3'd4;
  localparam logic [2:0] C_MORE_LEGS = 3'd5;

  localparam logic [3:0] A_IDLE  = 4'd0;
  localparam logic [3:0] A_MIX   = 4'd6;
  localparam logic [3:0] A_ZERO  = 4'd10;
  localparam logic [3:0] A_CLEAR = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       hold_in;
    logic       hold_out;
    logic [2:0] cond;
    logic [3:0] target;
  } ucw_t;

  function automatic ucw_t ucode(input logic [3:0] a);
    case (a)
      4'd0:    ucode = '{DP_LATCH,     1'b1, 1'b0, C_NEXT,      A_IDLE};
      4'd1:    ucode = '{DP_NOP,       1'b0, 1'b0, C_OP_ZERO,   A_ZERO};
      4'd2:    ucode = '{DP_NOP,       1'b0, 1'b0, C_OP_CLEAR,  A_CLEAR};
      4'd3:    ucode = '{DP_ERR,       1'b0, 1'b0, C_NOT_STEP,  A_IDLE};
      4'd4:    ucode = '{DP_MUL_ROLL,  1'b0, 1'b0, C_NEXT,      A_IDLE};
      4'd5:    ucode = '{DP_MUL_PITCH, 1'b0, 1'b0, C_NEXT,      A_IDLE};
      4'd6:    ucode = '{DP_MIX,       1'b0, 1'b0, C_NEXT,      A_IDLE};
      4'd7:    ucode = '{DP_TARGET,    1'b0, 1'b0, C_NEXT,      A_IDLE};
      4'd8:    ucode = '{DP_EMIT,      1'b0, 1'b1, C_MORE_LEGS, A_MIX};
      4'd9:    ucode = '{DP_NOP,       1'b0, 1'b0, C_ALWAYS,    A_IDLE};
      4'd10:   ucode = '{DP_ZERO,      1'b0, 1'b0, C_ALWAYS,    A_IDLE};
      4'd11:   ucode = '{DP_CLEAR,     1'b0, 1'b0, C_ALWAYS,    A_IDLE};
      default: ucode = '{DP_NOP,       1'b0, 1'b0, C_ALWAYS,    A_IDLE};
    endcase
  endfunction

  logic [3:0] step_r, step_nxt;
  ucw_t       uw;
  logic       hold;
  logic       take;

  assign uw    = ucode(step_r);
  assign dp_op = uw.op;
  assign hold  = (uw.hold_in && !st.in_valid) || (uw.hold_out && st.out_busy);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:    take = 1'b1;
      C_OP_ZERO:   take = st.op_zero;
      C_OP_CLEAR:  take = st.op_clear;
      C_NOT_STEP:  take = st.not_step;
      C_MORE_LEGS: take = st.more_legs;
      default:     take = 1'b0;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= A_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### design/llc_datapath.sv
// Datapath: reference, error, shared gain multiplier, leg mix, slew limit,
// leg offsets and the output register. Depends on llc_pkg and llc_ifs.
module llc_datapath #(
  parameter int LEGS = llc_pkg::LEGS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  llc_pkg::cfg_t    cfg,
  input  logic [3:0]       dp_op,
  output llc_pkg::status_t st,
  llc_in_if.sink           in_ch,
  llc_out_if.source        out_ch
);
  import llc_pkg::*;

  localparam int LW = (LEGS > 1) ? $clog2(LEGS) : 1;

  logic [1:0]         op_r;
  logic signed [16:0] roll_in_r, pitch_in_r;
  logic signed [16:0] roll_ref_r, pitch_ref_r;
  logic               ref_valid_r;
  logic signed [17:0] err_roll_r, err_pitch_r;
  logic signed [30:0] corr_roll_r, corr_pitch_r;
  logic signed [33:0] sum_r;
  logic signed [8:0]  target_r;
  logic [LW-1:0]      leg_r;
  logic signed [8:0]  offs_r [LEGS];

  logic              out_valid_r;
  logic [2:0]        out_leg_r;
  logic [8:0]        out_pulse_r;
  logic signed [8:0] out_offset_r;
  logic              out_last_r;

  function automatic logic signed [17:0] dead_err(input logic signed [16:0] meas,
                                                  input logic signed [16:0] base,
                                                  input logic [11:0] db);
    logic signed [17:0] d;
    logic [17:0]        m;
    d = 18'(meas) - 18'(base);
    m = d[17] ? 18'(-d) : 18'(d);
    dead_err = (m < {6'd0, db}) ? 18'sd0 : d;
  endfunction

  logic               accept, out_busy, fire, is_last;
  logic [2:0]         leg3;
  logic [11:0]        mul_gain;
  logic signed [12:0] mul_gain_s;
  logic signed [17:0] mul_err;
  logic               mul_inv;
  logic signed [30:0] prod, corr_nxt;
  logic signed [33:0] sum_nxt, smag, rnd;
  logic [16:0]        q;
  logic [7:0]         qc;
  logic signed [8:0]  qs, target_nxt;
  logic signed [8:0]  cur, next_off;
  logic signed [9:0]  delta, ms, stepv, nxt10;
  logic signed [11:0] psum;
  logic [8:0]         pulse;

  assign in_ch.ready = (dp_op == DP_LATCH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_busy    = out_valid_r && !out_ch.ready;
  assign fire        = (dp_op == DP_EMIT) && !out_busy;
  assign leg3        = 3'(leg_r);
  assign is_last     = (leg_r == LW'(LEGS - 1));

  assign st.in_valid  = in_ch.valid;
  assign st.out_busy  = out_busy;
  assign st.op_zero   = (op_r == OP_ZERO_REF);
  assign st.op_clear  = (op_r == OP_CLEAR_OFF);
  assign st.not_step  = !((op_r == OP_LEVEL) && ref_valid_r);
  assign st.more_legs = !is_last;

  // one multiplier serves both axes
  always_comb begin
    if (dp_op == DP_MUL_PITCH) begin
      mul_gain = cfg.pitch_gain;
      mul_err  = err_pitch_r;
      mul_inv  = cfg.pitch_invert;
    end else begin
      mul_gain = cfg.roll_gain;
      mul_err  = err_roll_r;
      mul_inv  = cfg.roll_invert;
    end
    mul_gain_s = {1'b0, mul_gain};
    prod       = mul_gain_s * mul_err;
    corr_nxt   = mul_inv ? prod : -prod;
  end

  // mix and round half away from zero, then saturate the magnitude
  always_comb begin
    sum_nxt = scale_w(34'(corr_roll_r), roll_w2(leg3))
            + scale_w(34'(corr_pitch_r), pitch_w(leg3));
    smag    = sum_r[33] ? -sum_r : sum_r;
    rnd     = smag + 34'sd65536;
    q       = rnd[33:17];
    qc      = (q > {9'd0, cfg.max_offset}) ? cfg.max_offset : q[7:0];
    qs      = {1'b0, qc};
    target_nxt = sum_r[33] ? -qs : qs;
  end

  // slew limit and pulse clamp
  always_comb begin
    cur   = offs_r[leg_r];
    ms    = {2'b00, cfg.max_step};
    delta = 10'(target_r) - 10'(cur);
    if (delta > ms) begin
      stepv = ms;
    end else if (delta < -ms) begin
      stepv = -ms;
    end else begin
      stepv = delta;
    end
    nxt10    = 10'(cur) + stepv;
    next_off = nxt10[8:0];
    psum     = {2'b00, neutral_of(cfg.neutral_pulses, leg3)} + 12'(next_off);
    if (psum < PULSE_MIN) begin
      pulse = 9'(PULSE_MIN);
    end else if (psum > PULSE_MAX) begin
      pulse = 9'(PULSE_MAX);
    end else begin
      pulse = psum[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
      roll_ref_r  <= '0;
      pitch_ref_r <= '0;
      leg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEGS; i++) begin
        offs_r[i] <= '0;
      end
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (dp_op)
        DP_LATCH: begin
          leg_r <= '0;
        end
        DP_ZERO: begin
          roll_ref_r  <= roll_in_r;
          pitch_ref_r <= pitch_in_r;
          ref_valid_r <= 1'b1;
          for (int i = 0; i < LEGS; i++) begin
            offs_r[i] <= '0;
          end
        end
        DP_CLEAR: begin
          for (int i = 0; i < LEGS; i++) begin
            offs_r[i] <= '0;
          end
        end
        DP_EMIT: begin
          if (fire) begin
            offs_r[leg_r] <= next_off;
            leg_r         <= leg_r + LW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_ch.opcode;
      roll_in_r  <= in_ch.roll_angle;
      pitch_in_r <= in_ch.pitch_angle;
    end
    if (dp_op == DP_ERR) begin
      err_roll_r  <= dead_err(roll_in_r, roll_ref_r, cfg.deadband);
      err_pitch_r <= dead_err(pitch_in_r, pitch_ref_r, cfg.deadband);
    end
    if (dp_op == DP_MUL_ROLL) begin
      corr_roll_r <= corr_nxt;
    end
    if (dp_op == DP_MUL_PITCH) begin
      corr_pitch_r <= corr_nxt;
    end
    if (dp_op == DP_MIX) begin
      sum_r <= sum_nxt;
    end
    if (dp_op == DP_TARGET) begin
      target_r <= target_nxt;
    end
    if (fire) begin
      out_leg_r    <= leg3;
      out_pulse_r  <= pulse;
      out_offset_r <= next_off;
      out_last_r   <= is_last;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.leg    = out_leg_r;
  assign out_ch.pulse  = out_pulse_r;
  assign out_ch.offset = out_offset_r;
  assign out_ch.last   = out_last_r;

endmodule

### design/leg_levelling_controller.sv
// Top level of the leg levelling controller: configuration registers,
// microcode sequencer and datapath. Depends on llc_pkg, llc_ifs and submodules.
// Usage:
//   in_ch carries one request: opcode, roll and pitch angle (signed Q8.8).
//   Opcode 1 latches the angles as reference and clears all leg offsets,
//   opcode 2 clears the offsets, opcode 0 runs one levelling step once a
//   reference exists; anything else is dropped without a result.
//   A levelling step returns LEGS requests on out_ch, leg 0 first, with
//   last set on the final leg. cfg_we/cfg_index/cfg_data write one register
//   per clock; write only while the block is idle.
// Sequence:
//   A sequencer walks a control store one step per cycle unless held. A level
//   step runs decode, error, two passes through the one gain multiplier, then
//   mix / round / slew for each leg in turn; each leg's result is registered at
//   its emit step. A new request is taken only after the last one is finished.
//   Opcodes 1 and 2 branch from decode; dropped requests leave at the error step.
// Reset and stall:
//   Synchronous reset restores the register defaults, clears the reference,
//   its valid flag and all offsets. A stalled receiver holds the sequencer
//   at the emit step; the pending result stays in the output register.
module leg_levelling_controller #(
  parameter int LEGS = llc_pkg::LEGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  llc_in_if.sink      in_ch,
  llc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import llc_pkg::*;

  cfg_t       cfg_r;
  status_t    st;
  logic [3:0] dp_op;

  // register file: one write per cycle, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roll_gain      <= ROLL_GAIN_RST;
      cfg_r.pitch_gain     <= PITCH_GAIN_RST;
      cfg_r.deadband       <= DEADBAND_RST;
      cfg_r.roll_invert    <= 1'b0;
      cfg_r.pitch_invert   <= 1'b0;
      cfg_r.max_offset     <= MAX_OFFSET_RST;
      cfg_r.max_step       <= MAX_STEP_RST;
      cfg_r.neutral_pulses <= NEUTRAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROLL_GAIN:    cfg_r.roll_gain      <= cfg_data[11:0];
        REG_PITCH_GAIN:   cfg_r.pitch_gain     <= cfg_data[11:0];
        REG_DEADBAND:     cfg_r.deadband       <= cfg_data[11:0];
        REG_ROLL_INVERT:  cfg_r.roll_invert    <= cfg_data[0];
        REG_PITCH_INVERT: cfg_r.pitch_invert   <= cfg_data[0];
        REG_MAX_OFFSET:   cfg_r.max_offset     <= cfg_data[7:0];
        REG_MAX_STEP:     cfg_r.max_step       <= cfg_data[7:0];
        REG_NEUTRAL:      cfg_r.neutral_pulses <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // advance the control store; hold on an empty input or a full output
  llc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .dp_op (dp_op)
  );

  llc_datapath #(
    .LEGS (LEGS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .dp_op  (dp_op),
    .st     (st),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### bench/leg_levelling_controller_test.sv
// Testbench of the leg levelling controller: a directed table, then random
// requests under bursty traffic and receiver stalls, each result checked.
// Depends on llc_pkg, llc_ifs and the leg_levelling_controller design.
module leg_levelling_controller_test;
  import llc_pkg::*;

  localparam int LEG_COUNT    = LEGS_DEF;
  localparam int ANGLE_LIMIT  = 46080;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRINT_CAP    = 30;

  // opcode 3 is not decoded by the block
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]        leg;
    logic [8:0]        pulse;
    logic signed [8:0] offset;
    logic              last;
  } leg_cmd_t;

  // ROW_REQ rows are checked against the predictor, ROW_NONE rows must give
  // no result, ROW_LEGS rows carry their six results typed in
  typedef enum logic [1:0] {ROW_REQ, ROW_NONE, ROW_LEGS, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         op;
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic [2:0]         reg_idx;
    logic [59:0]        reg_val;
    logic [5:0][8:0]    exp_pulse;
    logic [5:0][8:0]    exp_off;
  } plan_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_COMB} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [59:0] cfg_data = '0;

  llc_in_if  in_bus ();
  llc_out_if out_bus ();

  leg_levelling_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: shadow registers, reference and per-leg offsets
  // ---------------------------------------------------------------------
  cfg_t               shadow_cfg;
  logic signed [16:0] ref_roll, ref_pitch;
  logic               ref_set;
  longint             leg_off [LEG_COUNT];

  leg_cmd_t  pending_cmds [$];
  plan_row_t plan [$];
  int        req_tag = -1;

  int cycle_count = 0;
  int mismatches = 0;
  int n_requests = 0, n_steps = 0, n_results = 0, n_writes = 0;

  // driver-side view of the reference, used to aim angles near it
  int drv_ref_roll = 0, drv_ref_pitch = 0;
  int burst_left = 0;
  bit dirty = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // roll weight, already doubled
  function automatic longint roll_weight(input int leg);
    case (leg)
      0, 1, 2: return 2;
      3, 4, 5: return -2;
      default: return 0;
    endcase
  endfunction

  function automatic longint pitch_weight(input int leg);
    case (leg)
      0, 3:    return 2;
      1, 4:    return 1;
      2, 5:    return -2;
      default: return 0;
    endcase
  endfunction

  // proportional correction of one axis in ticks scaled by 2^-16
  function automatic longint axis_correction(input longint err, input logic [11:0] gain,
                                             input logic inv);
    longint mag;
    longint c;
    mag = (err < 0) ? -err : err;
    if (mag < longint'(shadow_cfg.deadband)) err = 0;
    c = -longint'(gain) * err;
    return inv ? -c : c;
  endfunction

  task automatic clear_leg_offsets();
    for (int i = 0; i < LEG_COUNT; i++) leg_off[i] = 0;
  endtask

  task automatic reset_predictor();
    shadow_cfg.roll_gain      = ROLL_GAIN_RST;
    shadow_cfg.pitch_gain     = PITCH_GAIN_RST;
    shadow_cfg.deadband       = DEADBAND_RST;
    shadow_cfg.roll_invert    = 1'b0;
    shadow_cfg.pitch_invert   = 1'b0;
    shadow_cfg.max_offset     = MAX_OFFSET_RST;
    shadow_cfg.max_step       = MAX_STEP_RST;
    shadow_cfg.neutral_pulses = NEUTRAL_RST;
    ref_roll  = '0;
    ref_pitch = '0;
    ref_set   = 1'b0;
    clear_leg_offsets();
  endtask

  // Advance the predictor by one accepted request and queue the leg
  // commands it is due to produce.
  task automatic predict_leg_cmds(input logic [1:0] op, input logic signed [16:0] roll,
                                  input logic signed [16:0] pitch, input int tag);
    longint   corr_r, corr_p, sum, mag, q, tgt, nxt, neutral, pulse;
    longint   lim, stp;
    leg_cmd_t cmd;
    bit       typed;
    typed = (tag >= 0) && (plan[tag].kind != ROW_REQ);
    case (op)
      OP_ZERO_REF: begin
        ref_roll  = roll;
        ref_pitch = pitch;
        ref_set   = 1'b1;
        clear_leg_offsets();
      end
      OP_CLEAR_OFF: clear_leg_offsets();
      OP_LEVEL: begin
        if (ref_set) begin
          n_steps++;
          corr_r = axis_correction(longint'(roll) - longint'(ref_roll),
                                   shadow_cfg.roll_gain, shadow_cfg.roll_invert);
          corr_p = axis_correction(longint'(pitch) - longint'(ref_pitch),
                                   shadow_cfg.pitch_gain, shadow_cfg.pitch_invert);
          lim = longint'(shadow_cfg.max_offset);
          stp = longint'(shadow_cfg.max_step);
          for (int i = 0; i < LEG_COUNT; i++) begin
            sum = roll_weight(i) * corr_r + pitch_weight(i) * corr_p;
            mag = (sum < 0) ? -sum : sum;
            // round half away from zero from 2^-17 ticks
            q   = (mag + 65536) >>> 17;
            tgt = clamp_to((sum < 0) ? -q : q, -lim, lim);
            nxt = leg_off[i] + clamp_to(tgt - leg_off[i], -stp, stp);
            leg_off[i] = nxt;
            neutral = (i < 6) ? longint'((shadow_cfg.neutral_pulses >> (10 * i)) & 60'h3FF) : 0;
            pulse = clamp_to(neutral + nxt, 50, 510);
            cmd.leg    = i[2:0];
            cmd.pulse  = pulse[8:0];
            cmd.offset = nxt[8:0];
            cmd.last   = (i == LEG_COUNT - 1);
            if (typed) begin
              cmd.pulse  = plan[tag].exp_pulse[i];
              cmd.offset = plan[tag].exp_off[i];
            end
            if (!typed || plan[tag].kind == ROW_LEGS) pending_cmds.push_back(cmd);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Track register writes and accepted requests at the clock edge, with the
  // values the block itself sees.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_predictor();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROLL_GAIN:    shadow_cfg.roll_gain      = cfg_data[11:0];
          REG_PITCH_GAIN:   shadow_cfg.pitch_gain     = cfg_data[11:0];
          REG_DEADBAND:     shadow_cfg.deadband       = cfg_data[11:0];
          REG_ROLL_INVERT:  shadow_cfg.roll_invert    = cfg_data[0];
          REG_PITCH_INVERT: shadow_cfg.pitch_invert   = cfg_data[0];
          REG_MAX_OFFSET:   shadow_cfg.max_offset     = cfg_data[7:0];
          REG_MAX_STEP:     shadow_cfg.max_step       = cfg_data[7:0];
          REG_NEUTRAL:      shadow_cfg.neutral_pulses = cfg_data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        n_requests++;
        predict_leg_cmds(in_bus.opcode, in_bus.roll_angle, in_bus.pitch_angle, req_tag);
      end
    end
  end

  // Compare every accepted leg command with the oldest one predicted.
  always @(posedge clk) begin
    leg_cmd_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      n_results++;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected result for leg %0d", out_bus.leg));
      end else begin
        want = pending_cmds.pop_front();
        if (out_bus.leg !== want.leg)
          report_mismatch($sformatf("leg %0d, expected %0d", out_bus.leg, want.leg));
        if (out_bus.pulse !== want.pulse)
          report_mismatch($sformatf("leg %0d pulse %0d, expected %0d",
                                    want.leg, out_bus.pulse, want.pulse));
        if (out_bus.offset !== want.offset)
          report_mismatch($sformatf("leg %0d offset %0d, expected %0d",
                                    want.leg, out_bus.offset, want.offset));
        if (out_bus.last !== want.last)
          report_mismatch($sformatf("leg %0d last %0b, expected %0b",
                                    want.leg, out_bus.last, want.last));
      end
    end
  end

  // Receiver: switch at random between stall patterns so that stalls land on
  // every leg of a step, with open stretches in between.
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_hold = 0;
  int         sink_phase = 0;

  always @(posedge clk) begin
    if (sink_hold == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_hold = $urandom_range(16, 160);
    end else begin
      sink_hold--;
    end
    sink_phase++;
    case (sink_mode)
      SINK_OPEN: out_bus.ready <= 1'b1;
      SINK_COIN: out_bus.ready <= $urandom_range(0, 1);
      SINK_SLOW: out_bus.ready <= ($urandom_range(0, 3) == 0);
      default:   out_bus.ready <= (sink_phase % 5) < 3;
    endcase
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_cmds.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic plan_row_t row_of(input row_kind_t kind, input logic [1:0] op,
                                       input int roll, input int pitch);
    plan_row_t r;
    r = '0;
    r.kind  = kind;
    r.op    = op;
    r.roll  = roll[16:0];
    r.pitch = pitch[16:0];
    return r;
  endfunction

  function automatic plan_row_t row_cfg(input logic [2:0] idx, input logic [59:0] val);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // a level step with its six pulses and offsets typed in, leg 0 first
  function automatic plan_row_t row_legs(input int roll, input int pitch,
                                         input int p0, input int p1, input int p2,
                                         input int p3, input int p4, input int p5,
                                         input int o0, input int o1, input int o2,
                                         input int o3, input int o4, input int o5);
    plan_row_t r;
    r = row_of(ROW_LEGS, OP_LEVEL, roll, pitch);
    r.exp_pulse[0] = p0[8:0]; r.exp_off[0] = o0[8:0];
    r.exp_pulse[1] = p1[8:0]; r.exp_off[1] = o1[8:0];
    r.exp_pulse[2] = p2[8:0]; r.exp_off[2] = o2[8:0];
    r.exp_pulse[3] = p3[8:0]; r.exp_off[3] = o3[8:0];
    r.exp_pulse[4] = p4[8:0]; r.exp_off[4] = o4[8:0];
    r.exp_pulse[5] = p5[8:0]; r.exp_off[5] = o5[8:0];
    return r;
  endfunction

  // Present one request and hold it until the block takes it. Between
  // bursts, drop valid for a random gap.
  task automatic send_request(input logic [1:0] op, input logic signed [16:0] roll,
                              input logic signed [16:0] pitch, input int tag);
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= op;
    in_bus.roll_angle  <= roll;
    in_bus.pitch_angle <= pitch;
    req_tag            <= tag;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    dirty = 1'b1;
    if (op == OP_ZERO_REF) begin
      drv_ref_roll  = roll;
      drv_ref_pitch = pitch;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Hold off until every predicted result is back and the block has had
  // time to finish a request that gives none.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    dirty = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
    if (dirty) wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_writes++;
  endtask

  // pull a value toward the corners of a register's range
  function automatic logic [59:0] pick_field(input logic [59:0] top, input logic [59:0] mid);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return top;
      2, 3:    return 60'({$urandom, $urandom} % (mid + 1));
      default: return 60'({$urandom, $urandom} % (top + 1));
    endcase
  endfunction

  task automatic random_config();
    if ($urandom_range(0, 1)) write_reg(REG_ROLL_GAIN, pick_field(60'd4095, 60'd600));
    if ($urandom_range(0, 1)) write_reg(REG_PITCH_GAIN, pick_field(60'd4095, 60'd600));
    if ($urandom_range(0, 1)) write_reg(REG_DEADBAND, pick_field(60'd4095, 60'd400));
    if ($urandom_range(0, 1)) write_reg(REG_ROLL_INVERT, 60'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) write_reg(REG_PITCH_INVERT, 60'($urandom_range(0, 1)));
    write_reg(REG_MAX_OFFSET, pick_field(60'd255, 60'd60));
    write_reg(REG_MAX_STEP, pick_field(60'd255, 60'd8));
    if ($urandom_range(0, 1)) write_reg(REG_NEUTRAL, 60'({$urandom, $urandom}));
  endtask

  // half the time near the reference, so deadband and unsaturated mixing are hit
  function automatic logic signed [16:0] pick_angle(input int center);
    int v;
    case ($urandom_range(0, 9))
      0:             v = ANGLE_LIMIT;
      1:             v = -ANGLE_LIMIT;
      2, 3, 4, 5, 6: v = center + int'($urandom_range(0, 2400)) - 1200;
      default:       v = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
    endcase
    if (v > ANGLE_LIMIT) v = ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) v = -ANGLE_LIMIT;
    return v[16:0];
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [1:0] op;
    int         counted;
    int         next_cfg_at;

    in_bus.valid       = 1'b0;
    in_bus.opcode      = OP_LEVEL;
    in_bus.roll_angle  = '0;
    in_bus.pitch_angle = '0;
    out_bus.ready      = 1'b0;

    // Directed table. Register defaults apply until the first write:
    // gains 307, deadband 179, max offset 35, max step 2,
    // neutral pulses 160 170 200 300 160 230.
    plan.push_back(row_of(ROW_NONE, OP_LEVEL, 0, 0));              // no reference yet
    plan.push_back(row_of(ROW_NONE, OP_LEVEL, ANGLE_LIMIT, -ANGLE_LIMIT));
    plan.push_back(row_of(ROW_NONE, OP_ZERO_REF, 0, 0));
    plan.push_back(row_legs(0, 0, 160, 170, 200, 300, 160, 230, 0, 0, 0, 0, 0, 0));
    // just inside the deadband
    plan.push_back(row_legs(178, -178, 160, 170, 200, 300, 160, 230, 0, 0, 0, 0, 0, 0));
    // full roll error: target saturates, slew moves two ticks a step
    plan.push_back(row_legs(ANGLE_LIMIT, 0, 158, 168, 198, 302, 162, 232, -2, -2, -2, 2, 2, 2));
    plan.push_back(row_legs(ANGLE_LIMIT, 0, 156, 166, 196, 304, 164, 234, -4, -4, -4, 4, 4, 4));
    plan.push_back(row_of(ROW_NONE, OP_CLEAR_OFF, 0, 0));
    plan.push_back(row_of(ROW_NONE, OP_UNKNOWN, ANGLE_LIMIT, ANGLE_LIMIT));
    plan.push_back(row_legs(0, ANGLE_LIMIT, 158, 168, 202, 298, 158, 232, -2, -2, 2, -2, -2, 2));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, 179, -179));          // on the deadband edge
    plan.push_back(row_of(ROW_NONE, OP_ZERO_REF, -ANGLE_LIMIT, ANGLE_LIMIT));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, ANGLE_LIMIT, -ANGLE_LIMIT));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, -ANGLE_LIMIT, ANGLE_LIMIT));
    // widest settings; neutral 1023 pins every pulse at the top
    plan.push_back(row_cfg(REG_ROLL_GAIN, 60'd4095));
    plan.push_back(row_cfg(REG_PITCH_GAIN, 60'd4095));
    plan.push_back(row_cfg(REG_DEADBAND, 60'd0));
    plan.push_back(row_cfg(REG_MAX_OFFSET, 60'd255));
    plan.push_back(row_cfg(REG_MAX_STEP, 60'd255));
    plan.push_back(row_cfg(REG_ROLL_INVERT, 60'd1));
    plan.push_back(row_cfg(REG_PITCH_INVERT, 60'd1));
    plan.push_back(row_cfg(REG_NEUTRAL, {60{1'b1}}));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, ANGLE_LIMIT, ANGLE_LIMIT));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, -ANGLE_LIMIT, -ANGLE_LIMIT));
    // neutral 0 drives every pulse whose offset lies below 50 to the bottom clamp
    plan.push_back(row_cfg(REG_NEUTRAL, 60'd0));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, ANGLE_LIMIT, -ANGLE_LIMIT));
    // lower the limit: stored offsets creep back one tick per step
    plan.push_back(row_cfg(REG_MAX_OFFSET, 60'd10));
    plan.push_back(row_cfg(REG_MAX_STEP, 60'd1));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, -ANGLE_LIMIT, ANGLE_LIMIT));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, -ANGLE_LIMIT, ANGLE_LIMIT));
    // zero step: offsets freeze
    plan.push_back(row_cfg(REG_MAX_STEP, 60'd0));
    plan.push_back(row_cfg(REG_ROLL_INVERT, 60'd0));
    plan.push_back(row_cfg(REG_PITCH_INVERT, 60'd0));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, 0, 0));
    // zero limit with a full deadband: offsets snap to zero
    plan.push_back(row_cfg(REG_MAX_OFFSET, 60'd0));
    plan.push_back(row_cfg(REG_MAX_STEP, 60'd255));
    plan.push_back(row_cfg(REG_DEADBAND, 60'd4095));
    plan.push_back(row_cfg(REG_NEUTRAL, NEUTRAL_RST));
    plan.push_back(row_of(ROW_REQ, OP_LEVEL, 0, 0));
    plan.push_back(row_of(ROW_NONE, OP_ZERO_REF, 0, 0));
    // back to the defaults for the random part
    plan.push_back(row_cfg(REG_ROLL_GAIN, ROLL_GAIN_RST));
    plan.push_back(row_cfg(REG_PITCH_GAIN, PITCH_GAIN_RST));
    plan.push_back(row_cfg(REG_DEADBAND, DEADBAND_RST));
    plan.push_back(row_cfg(REG_MAX_OFFSET, MAX_OFFSET_RST));
    plan.push_back(row_cfg(REG_MAX_STEP, MAX_STEP_RST));

    // hold reset, then release it at a clock edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_request(plan[i].op, plan[i].roll, plan[i].pitch, i);
    end

    // Random part: mostly level steps around the current reference, with
    // occasional re-zeroing, clears, undecoded opcodes and drained pauses.
    counted = 0;
    next_cfg_at = $urandom_range(40, 100);
    while (counted < RANDOM_ITEMS) begin
      if (counted == next_cfg_at) begin
        random_config();
        next_cfg_at += $urandom_range(40, 100);
      end else if ($urandom_range(0, 99) == 0) begin
        wait_idle();
      end
      case ($urandom_range(0, 99)) inside
        [0:83]:  op = OP_LEVEL;
        [84:89]: op = OP_ZERO_REF;
        [90:94]: op = OP_CLEAR_OFF;
        default: op = OP_UNKNOWN;
      endcase
      counted++;
      send_request(op, pick_angle(drv_ref_roll), pick_angle(drv_ref_pitch), -1);
    end

    wait_idle();

    $display("covered %0d requests, %0d level steps, %0d leg results, %0d register writes",
             n_requests, n_steps, n_results, n_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
design/llc_pkg.sv
design/llc_ifs.sv
design/llc_sequencer.sv
design/llc_datapath.sv
design/leg_levelling_controller.sv
bench/leg_levelling_controller_test.sv
